// ===== design/swk_pkg.sv =====
package swk_pkg;

  // Field widths fixed by the interface
  localparam int unsigned PosW  = 16;
  localparam int unsigned NeedW = 7;

  // Default depth of the ones ring
  localparam int unsigned MaxOnesDef = 64;

  // Longest counted sequence; later bits are dropped and flagged
  localparam int unsigned MaxLen = 65535;

  // Register map (word index = paddr[2])
  localparam logic RegOnesNeeded = 1'b0;

  // Reset value of the ones_needed register
  localparam logic [NeedW-1:0] OnesNeededRst = NeedW'(1);

  // One accepted bit after the tracking stage
  typedef struct packed {
    logic            last;       // ends the sequence
    logic            cmp;        // candidate window closes on this bit
    logic            k_one;      // window of one one: length is 1
    logic [PosW-1:0] idx;        // position of this bit
    logic [PosW-1:0] pos_after;  // bit count after this bit
    logic            ovf_after;  // overflow flag after this bit
  } swk_item_t;

endpackage

// ===== design/swk_ram.sv =====
module swk_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port, one registered read port (read returns old data)
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/swk_track.sv =====
module swk_track #(
  parameter int unsigned MaxOnes = swk_pkg::MaxOnesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       bit_value_i,
  input  logic                       last_bit_i,
  input  logic [swk_pkg::NeedW-1:0]  ones_needed_i,
  input  logic                       advance_i,
  output logic                       item_valid_o,
  output swk_pkg::swk_item_t         item_o,
  output logic [swk_pkg::PosW-1:0]   ring_rdata_o
);
  import swk_pkg::*;

  localparam int unsigned PtrW = (MaxOnes > 1) ? $clog2(MaxOnes) : 1;
  localparam int unsigned CntW = $clog2(MaxOnes + 1);
  localparam int unsigned AW   = ((CntW > NeedW) ? CntW : NeedW) + 1;

  logic [PosW-1:0] pos_q, pos_d;
  logic [PtrW-1:0] ptr_q, ptr_d;
  logic [CntW-1:0] seen_q, seen_d;
  logic            ovf_q, ovf_d;
  logic            valid_q, valid_d;
  swk_item_t       item_q, item_d;

  logic            accept;
  logic            in_range;
  logic            take_one;
  logic [CntW-1:0] seen_next;
  logic [AW-1:0]   k_ext, km1_ext, ptr_ext, seen_ext, back_ext;
  logic            k_ok;
  logic [PtrW-1:0] raddr;

  // Stage slot frees when the next stage takes its word
  assign in_ready_o = !valid_q || advance_i;
  assign accept     = in_valid_i && in_ready_o;

  assign in_range = pos_q < PosW'(MaxLen);
  assign take_one = accept && in_range && bit_value_i;

  assign seen_next = (seen_q < CntW'(MaxOnes)) ? seen_q + CntW'(1) : seen_q;

  // Slot of the one that lies k-1 ones back
  assign k_ext    = AW'(ones_needed_i);
  assign km1_ext  = k_ext - AW'(1);
  assign ptr_ext  = AW'(ptr_q);
  assign seen_ext = AW'(seen_next);
  assign k_ok     = (ones_needed_i != '0) && (k_ext <= AW'(MaxOnes));
  assign back_ext = (ptr_ext >= km1_ext) ? ptr_ext - km1_ext
                                         : ptr_ext + AW'(MaxOnes) - km1_ext;
  assign raddr    = back_ext[PtrW-1:0];

  // Sequence state update
  always_comb begin
    pos_d  = pos_q;
    ptr_d  = ptr_q;
    seen_d = seen_q;
    ovf_d  = ovf_q;
    if (accept) begin
      if (last_bit_i) begin
        pos_d  = '0;
        ptr_d  = '0;
        seen_d = '0;
        ovf_d  = 1'b0;
      end else if (!in_range) begin
        ovf_d = 1'b1;
      end else begin
        pos_d = pos_q + PosW'(1);
        if (bit_value_i) begin
          ptr_d  = (ptr_q == PtrW'(MaxOnes - 1)) ? '0 : ptr_q + PtrW'(1);
          seen_d = seen_next;
        end
      end
    end
  end

  // Word handed to the min stage
  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
    item_d.last      = last_bit_i;
    item_d.cmp       = take_one && k_ok && (seen_ext >= k_ext);
    item_d.k_one     = (ones_needed_i == NeedW'(1));
    item_d.idx       = pos_q;
    item_d.pos_after = in_range ? pos_q + PosW'(1) : pos_q;
    item_d.ovf_after = ovf_q || !in_range;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      ptr_q   <= '0;
      seen_q  <= '0;
      ovf_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      ptr_q   <= ptr_d;
      seen_q  <= seen_d;
      ovf_q   <= ovf_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  // Ring of one positions; a window of one one reads the slot being written, but its length is taken as 1
  swk_ram #(
    .Width (PosW),
    .Depth (MaxOnes)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (take_one),
    .waddr_i (ptr_q),
    .wdata_i (pos_q),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (ring_rdata_o)
  );

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ===== design/swk_best.sv =====
module swk_best (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     item_valid_i,
  input  swk_pkg::swk_item_t       item_i,
  input  logic [swk_pkg::PosW-1:0] ring_rdata_i,
  output logic                     advance_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     found_o,
  output logic [swk_pkg::PosW-1:0] min_length_o,
  output logic [swk_pkg::PosW-1:0] seq_length_o,
  output logic                     overflow_o
);
  import swk_pkg::*;

  logic [PosW-1:0] best_q, best_d;
  logic            bv_q, bv_d;
  logic            out_valid_q, out_valid_d;
  logic            found_q;
  logic [PosW-1:0] min_q, seq_q;
  logic            ovf_q;

  logic [PosW-1:0] len;
  logic            better;
  logic            new_bv;
  logic [PosW-1:0] new_best;
  logic            out_free;
  logic            load_out;

  // Candidate length and running minimum
  assign len      = item_i.k_one ? PosW'(1) : item_i.idx - ring_rdata_i + PosW'(1);
  assign better   = item_i.cmp && (!bv_q || (len < best_q));
  assign new_bv   = bv_q || item_i.cmp;
  assign new_best = better ? len : best_q;

  // Only a closing bit needs room in the result register
  assign out_free  = !out_valid_q || out_ready_i;
  assign advance_o = item_valid_i && (!item_i.last || out_free);
  assign load_out  = advance_o && item_i.last;

  always_comb begin
    best_d      = best_q;
    bv_d        = bv_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (advance_o) begin
      if (item_i.last) begin
        best_d      = '1;
        bv_d        = 1'b0;
        out_valid_d = 1'b1;
      end else begin
        best_d = new_best;
        bv_d   = new_bv;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q      <= '1;
      bv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      best_q      <= best_d;
      bv_q        <= bv_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      found_q <= new_bv;
      min_q   <= new_bv ? new_best : '0;
      seq_q   <= item_i.pos_after;
      ovf_q   <= item_i.ovf_after;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign found_o      = found_q;
  assign min_length_o = min_q;
  assign seq_length_o = seq_q;
  assign overflow_o   = ovf_q;

endmodule

// ===== design/shortest_window_k_ones_top.sv =====
// Channel  | Handshake              | Payload
// ---------+------------------------+------------------------------------------
// in       | in_valid_i/in_ready_o  | bit_value_i, last_bit_i
// out      | out_valid_o/out_ready_i| found_o, min_length_o, seq_length_o,
//          |                        | overflow_o
// config   | APB psel/penable       | paddr, pwdata, prdata (ones_needed @ 0x0)
//
// One bit accepted per cycle while no closing bit waits on a full result register;
// a result is registered through the tracking register, then the result register.
// The ring read for the window start is issued on the accept edge; its registered
// data is used together with the tracked word by the result stage.
// A full, stalled result register holds only closing bits; other bits keep
// flowing. Reset is asynchronous and needs no clearing pass.
module shortest_window_k_ones_top #(
  parameter int unsigned MaxOnes = swk_pkg::MaxOnesDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // bit stream
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     bit_value_i,
  input  logic                     last_bit_i,
  // results
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     found_o,
  output logic [swk_pkg::PosW-1:0] min_length_o,
  output logic [swk_pkg::PosW-1:0] seq_length_o,
  output logic                     overflow_o,
  // register port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import swk_pkg::*;

  logic [NeedW-1:0] ones_needed_q;
  logic             cfg_wr;
  logic             advance;
  logic             item_valid;
  swk_item_t        item;
  logic [PosW-1:0]  ring_rdata;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegOnesNeeded);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ones_needed_q <= OnesNeededRst;
    end else if (cfg_wr) begin
      ones_needed_q <= pwdata[NeedW-1:0];
    end
  end

  assign prdata = (paddr[2] == RegOnesNeeded) ? 32'(ones_needed_q) : '0;

  swk_track #(
    .MaxOnes (MaxOnes)
  ) u_track (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .bit_value_i   (bit_value_i),
    .last_bit_i    (last_bit_i),
    .ones_needed_i (ones_needed_q),
    .advance_i     (advance),
    .item_valid_o  (item_valid),
    .item_o        (item),
    .ring_rdata_o  (ring_rdata)
  );

  swk_best u_best (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .ring_rdata_i (ring_rdata),
    .advance_o    (advance),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .found_o      (found_o),
    .min_length_o (min_length_o),
    .seq_length_o (seq_length_o),
    .overflow_o   (overflow_o)
  );

endmodule

// ===== design/swk_checker.sv =====
module swk_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     last_bit_i,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic                     found_o,
  input logic [swk_pkg::PosW-1:0] min_length_o,
  input logic [swk_pkg::PosW-1:0] seq_length_o,
  input logic                     overflow_o
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(found_o) &&
      $stable(min_length_o) && $stable(seq_length_o) && $stable(overflow_o))
    else $error("result word changed while stalled");

  // An accepted closing bit is followed by a valid result word
  a_close_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_bit_i |-> ##2 out_valid_o)
    else $error("closing bit produced no result");

  // A result only follows a closing bit
  a_out_from_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && last_bit_i, 2))
    else $error("result without closing bit");

  // Window length is zero when not found and within the sequence otherwise
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (found_o ? (min_length_o != '0 && min_length_o <= seq_length_o)
                             : (min_length_o == '0)))
    else $error("window length out of range");

endmodule

bind shortest_window_k_ones_top swk_checker u_swk_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .last_bit_i   (last_bit_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .found_o      (found_o),
  .min_length_o (min_length_o),
  .seq_length_o (seq_length_o),
  .overflow_o   (overflow_o)
);

// ===== sim/tb_shortest_window_k_ones_top.sv =====
module tb_shortest_window_k_ones_top;
  import swk_pkg::*;

  localparam int unsigned RingDepth = MaxOnesDef;
  localparam int unsigned RingW     = $clog2(RingDepth);
  localparam int unsigned HalfPer   = 6;
  localparam int unsigned RandWords = 1250;
  localparam int unsigned DrainWait = 8;
  localparam logic [2:0]  NeedAddr  = {RegOnesNeeded, 2'b00};
  // first word address past the register map
  localparam logic [2:0]  SpareAddr = 3'd4;

  typedef struct packed {
    logic            found;
    logic [PosW-1:0] min_len;
    logic [PosW-1:0] seq_len;
    logic            ovf;
  } window_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              bit_value_i = 1'b0;
  logic              last_bit_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              found_o;
  logic [PosW-1:0]   min_length_o;
  logic [PosW-1:0]   seq_length_o;
  logic              overflow_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  shortest_window_k_ones_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .bit_value_i (bit_value_i),
    .last_bit_i  (last_bit_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .found_o     (found_o),
    .min_length_o(min_length_o),
    .seq_length_o(seq_length_o),
    .overflow_o  (overflow_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #HalfPer clk_i = 1'b1;
    #HalfPer clk_i = 1'b0;
  end

  // Predictor state: mirror of the sequence tracker
  logic [PosW-1:0]  one_pos [RingDepth];
  logic [RingW-1:0] ring_wr;
  logic [NeedW:0]   ones_cnt;
  logic [PosW-1:0]  bit_pos;
  logic [PosW-1:0]  best_len;
  logic             best_ok;
  logic             seq_ovf;
  logic [NeedW-1:0] need_ones;

  window_result_t window_q[$];
  int unsigned    err_count;
  int unsigned    words_sent;
  int unsigned    send_gap_max;
  int unsigned    stall_max;

  function automatic void clear_window_state();
    ring_wr  = '0;
    ones_cnt = '0;
    bit_pos  = '0;
    best_len = '1;
    best_ok  = 1'b0;
    seq_ovf  = 1'b0;
  endfunction

  // Track one accepted bit; queue the expected result on the last one
  function automatic void track_bit(input logic b, input logic l);
    logic [RingW-1:0] slot;
    logic [RingW-1:0] back;
    logic [PosW-1:0]  idx;
    logic [PosW-1:0]  wlen;
    window_result_t   res;
    if (bit_pos >= PosW'(MaxLen)) begin
      seq_ovf = 1'b1;
    end else begin
      idx = bit_pos;
      bit_pos = bit_pos + 1'b1;
      if (b) begin
        slot = ring_wr;
        one_pos[slot] = idx;
        ring_wr = slot + 1'b1;
        if (ones_cnt < (NeedW+1)'(RingDepth)) ones_cnt = ones_cnt + 1'b1;
        if (need_ones >= 1 && need_ones <= RingDepth &&
            ones_cnt >= (NeedW+1)'(need_ones)) begin
          back = slot - RingW'(need_ones - 1);
          wlen = idx - one_pos[back] + 1'b1;
          if (!best_ok || wlen < best_len) begin
            best_len = wlen;
            best_ok  = 1'b1;
          end
        end
      end
    end
    if (l) begin
      res.found   = best_ok;
      res.min_len = best_ok ? best_len : '0;
      res.seq_len = bit_pos;
      res.ovf     = seq_ovf;
      window_q.push_back(res);
      clear_window_state();
    end
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    err_count++;
  endtask

  // Send one word; called and returns at a rising edge
  task automatic send_bit(input logic b, input logic l);
    int unsigned gap;
    logic        rdy;
    gap = (send_gap_max > 0) ? $urandom_range(send_gap_max, 0) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    bit_value_i <= b;
    last_bit_i  <= l;
    do begin
      @(negedge clk_i);
      rdy = in_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    track_bit(b, l);
    words_sent++;
  endtask

  // Send a short sequence given as a bit string, MSB first
  task automatic send_pattern(input logic [63:0] bits, input int unsigned n);
    for (int i = n - 1; i >= 0; i--) send_bit(bits[i], i == 0);
  endtask

  // Hold off until every result is back and the pipeline has emptied
  task automatic settle_idle();
    in_valid_i <= 1'b0;
    while (window_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    logic rdy;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      rdy = pready;
      @(posedge clk_i);
    end while (!rdy);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == NeedAddr) need_ones = data[NeedW-1:0];
  endtask

  task automatic set_need(input logic [NeedW-1:0] k);
    settle_idle();
    write_reg(NeedAddr, ($urandom() & ~32'h7F) | 32'(k));
  endtask

  // Result side: random stalls, compare each word with the oldest expectation
  initial begin
    int unsigned    stall;
    logic           took;
    window_result_t got;
    window_result_t want;
    @(posedge rst_ni);
    forever begin
      stall = (stall_max > 0) ? $urandom_range(stall_max, 0) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do begin
        @(negedge clk_i);
        took = out_valid_o;
        got  = '{found_o, min_length_o, seq_length_o, overflow_o};
        @(posedge clk_i);
      end while (!took);
      if (window_q.size() == 0) begin
        report_mismatch("result with nothing expected", 1, 0);
      end else begin
        want = window_q.pop_front();
        if (got.found !== want.found)
          report_mismatch("found", got.found, want.found);
        if (got.min_len !== want.min_len)
          report_mismatch("min_length", got.min_len, want.min_len);
        if (got.seq_len !== want.seq_len)
          report_mismatch("seq_length", got.seq_len, want.seq_len);
        if (got.ovf !== want.ovf)
          report_mismatch("overflow", got.ovf, want.ovf);
      end
    end
  end

  // Default register value, single-bit sequences, shortest window of one
  task automatic test_reset_default();
    send_pattern(64'b0, 1);
    send_pattern(64'b1, 1);
    send_pattern(64'b01001, 5);
  endtask

  // Windows of two, and fewer ones than needed
  task automatic test_directed_windows();
    set_need(2);
    send_pattern(64'b100101, 6);
    set_need(3);
    send_pattern(64'b1001, 4);
  endtask

  // Zero and above-depth counts never match; spare address is ignored
  task automatic test_need_out_of_range();
    set_need(0);
    send_pattern(64'b11, 2);
    set_need(65);
    send_pattern(64'b11, 2);
    settle_idle();
    write_reg(NeedAddr, 32'hFFFF_FFFF);
    send_pattern(64'b1, 1);
    set_need(3);
    // idle time between the two register writes
    @(posedge clk_i);
    write_reg(SpareAddr, 32'h1);
    send_pattern(64'b11, 2);
  endtask

  // Longest counted sequence, then one two bits past it with dropped ones and last bit
  task automatic test_length_limit();
    int unsigned n;
    set_need(2);
    send_gap_max = 0;
    stall_max    = 0;
    for (int pass = 0; pass < 2; pass++) begin
      n = (pass == 0) ? MaxLen : MaxLen + 2;
      for (int unsigned i = 0; i < n; i++)
        send_bit(i == 0 || i == MaxLen - 1 || i >= MaxLen, i == n - 1);
    end
  endtask

  // Random sequences over a range of required counts
  task automatic test_random_sequences();
    logic [NeedW-1:0] need_list [10] = '{1, 2, 3, 5, 8, 16, 32, 63, 64, 1};
    logic [NeedW-1:0] k;
    int unsigned      phase_end;
    int unsigned      len;
    int unsigned      dens;
    int unsigned      rand_start;
    rand_start = words_sent;
    for (int p = 0; words_sent - rand_start < RandWords; p++) begin
      k = (p < 10) ? need_list[p] : NeedW'($urandom_range(RingDepth, 1));
      if (p == 9) k = NeedW'($urandom_range(RingDepth, 1));
      set_need(k);
      // some phases run without gaps on one or both sides
      send_gap_max = (p % 4 == 1) ? 0 : 11;
      stall_max    = (p % 3 == 2) ? 0 : 11;
      phase_end = words_sent + 125;
      while (words_sent < phase_end) begin
        case ($urandom_range(5, 0))
          0: begin
            len  = $urandom_range(16, 1);
            dens = $urandom_range(100, 0);
          end
          1: begin
            len  = $urandom_range(24, 1);
            dens = ($urandom_range(1, 0) == 1) ? 100 : 0;
          end
          default: begin
            len  = $urandom_range(2 * k + 20, k);
            dens = $urandom_range(100, (k > 8) ? 70 : 20);
          end
        endcase
        for (int unsigned i = 0; i < len; i++)
          send_bit($urandom_range(100, 1) <= dens, i == len - 1);
      end
    end
  endtask

  initial begin
    err_count    = 0;
    words_sent   = 0;
    send_gap_max = 11;
    stall_max    = 11;
    need_ones    = OnesNeededRst;
    clear_window_state();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_default();
    test_directed_windows();
    test_need_out_of_range();
    test_length_limit();
    test_random_sequences();

    settle_idle();
    repeat (DrainWait) @(posedge clk_i);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #(2 * HalfPer * 2_000_000);
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
design/swk_pkg.sv
design/swk_ram.sv
design/swk_track.sv
design/swk_best.sv
design/shortest_window_k_ones_top.sv
design/swk_checker.sv
sim/tb_shortest_window_k_ones_top.sv
